// ===== hw/rtl/ppm_capture_decoder_core_macros.svh =====
// assertion macros for the ppm capture decoder core
// used by the top level only; expects clk and rst_n in scope
`ifndef PPM_CAPTURE_DECODER_CORE_MACROS_SVH
`define PPM_CAPTURE_DECODER_CORE_MACROS_SVH

// property checked every clock outside reset
`define PPMCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: consequent checked in the cycle after the antecedent
`define PPMCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ppmcd_pkg.sv =====
// shared constants, register codes and request structs of the ppm decoder
// no dependencies
package ppmcd_pkg;

  localparam int CHANNELS   = 8;
  localparam int READ_COUNT = 8;
  localparam int ADDR_W     = $clog2(READ_COUNT);
  localparam int SLOT_W     = $clog2(CHANNELS + 1);
  localparam int CAP_W      = 16;
  localparam int MINCH_W    = 4;
  localparam int PULSE_W    = 15;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CAP_W-1:0]   RAW_RESET       = 16'd2400;
  localparam logic [CAP_W-1:0]   TIMER_TOP_RESET = 16'd40000;
  localparam logic [CAP_W-1:0]   SYNC_GAP_RESET  = 16'd8000;
  localparam logic [MINCH_W-1:0] MIN_CH_RESET    = 4'd5;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 15'd900;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 15'd2100;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_TOP = 3'd0,
    REG_SYNC_GAP  = 3'd1,
    REG_MIN_CH    = 3'd2,
    REG_MIN_PULSE = 3'd3,
    REG_MAX_PULSE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CAP_W-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ===== hw/rtl/ppmcd_store.sv =====
// channel width memory, one write and one registered read port
// per-entry valid bits give the reset width for entries never written; uses ppmcd_pkg
module ppmcd_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppmcd_pkg::wr_req_t                wr,
  input  ppmcd_pkg::rd_req_t                rd,
  output logic [ppmcd_pkg::CAP_W-1:0]       rd_data
);
  import ppmcd_pkg::*;

  logic [CAP_W-1:0]      mem [READ_COUNT];
  logic [READ_COUNT-1:0] valid_r;
  logic [CAP_W-1:0]      q_r;
  logic                  qv_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        qv_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_data = qv_r ? q_r : RAW_RESET;

endmodule

// ===== hw/rtl/ppmcd_capture.sv =====
// capture path: gap between timestamps, sync detection, slot index and new-frame flag
// issues width writes to ppmcd_store; uses ppmcd_pkg
module ppmcd_capture (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cap_go,
  input  logic [ppmcd_pkg::CAP_W-1:0]       cap_time,
  input  logic                              frame_clr,
  input  logic [ppmcd_pkg::CAP_W-1:0]       timer_top,
  input  logic [ppmcd_pkg::CAP_W-1:0]       sync_gap,
  input  logic [ppmcd_pkg::MINCH_W-1:0]     min_ch,
  output ppmcd_pkg::wr_req_t                wr,
  output logic                              new_frame
);
  import ppmcd_pkg::*;

  logic [CAP_W-1:0]  prev_r;
  logic [SLOT_W-1:0] slot_r;
  logic              new_frame_r;
  logic              wrap;
  logic [CAP_W-1:0]  gap;
  logic              is_sync;
  logic              slot_open;

  assign wrap      = cap_time < prev_r;
  assign gap       = CAP_W'(cap_time - prev_r + (wrap ? timer_top : '0));
  assign is_sync   = gap > sync_gap;
  assign slot_open = 32'(slot_r) < CHANNELS;

  assign wr.en   = cap_go && !is_sync && slot_open && (32'(slot_r) < READ_COUNT);
  assign wr.addr = ADDR_W'(slot_r);
  assign wr.data = gap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      slot_r      <= '0;
      new_frame_r <= 1'b0;
    end else begin
      if (cap_go) begin
        prev_r <= cap_time;
        if (is_sync) begin
          if (32'(slot_r) >= 32'(min_ch)) begin
            new_frame_r <= 1'b1;
          end
          slot_r <= '0;
        end else if (slot_open) begin
          slot_r <= SLOT_W'(slot_r + 1'b1);
        end
      end else if (frame_clr) begin
        new_frame_r <= 1'b0;
      end
    end
  end

  assign new_frame = new_frame_r;

endmodule

// ===== hw/rtl/ppmcd_reader.sv =====
// read sequencer: walks the stored widths one per cycle, halves and clamps them
// drives the result ports through an output register; uses ppmcd_pkg
module ppmcd_reader (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_go,
  input  logic                              new_frame,
  input  logic [ppmcd_pkg::CAP_W-1:0]       rd_data,
  input  logic [ppmcd_pkg::PULSE_W-1:0]     min_pulse,
  input  logic [ppmcd_pkg::PULSE_W-1:0]     max_pulse,
  output ppmcd_pkg::rd_req_t                rd,
  output logic                              busy,
  output logic                              out_strobe,
  output logic [ppmcd_pkg::IDX_W-1:0]       out_channel_index,
  output logic [ppmcd_pkg::PULSE_W-1:0]     out_pulse_us,
  output logic                              out_frame_valid,
  output logic                              out_last
);
  import ppmcd_pkg::*;

  typedef enum logic [1:0] {
    RD_IDLE  = 2'b01,
    RD_ISSUE = 2'b10
  } rd_state_t;

  rd_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              dat_vld_r;
  logic [ADDR_W-1:0] dat_idx_r;
  logic              strobe_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PULSE_W-1:0] pulse_r;
  logic              fv_r;
  logic              last_r;
  logic [PULSE_W-1:0] half;
  logic [PULSE_W-1:0] clamped;

  assign half    = rd_data[CAP_W-1:1];
  assign clamped = (half < min_pulse) ? min_pulse :
                   (half > max_pulse) ? max_pulse : half;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    case (state_r)
      RD_IDLE: begin
        if (rd_go && new_frame) begin
          state_nxt = RD_ISSUE;
          addr_nxt  = '0;
        end
      end
      RD_ISSUE: begin
        addr_nxt = ADDR_W'(addr_r + 1'b1);
        if (addr_r == ADDR_W'(READ_COUNT - 1)) begin
          state_nxt = RD_IDLE;
        end
      end
      default: begin
        state_nxt = RD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= RD_IDLE;
      addr_r    <= '0;
      dat_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      dat_vld_r <= (state_r == RD_ISSUE);
      strobe_r  <= dat_vld_r || (rd_go && !new_frame);
    end
  end

  always_ff @(posedge clk) begin
    dat_idx_r <= addr_r;
    if (dat_vld_r) begin
      idx_r   <= IDX_W'(dat_idx_r);
      pulse_r <= clamped;
      fv_r    <= 1'b1;
      last_r  <= (dat_idx_r == ADDR_W'(READ_COUNT - 1));
    end else begin
      idx_r   <= '0;
      pulse_r <= '0;
      fv_r    <= 1'b0;
      last_r  <= 1'b1;
    end
  end

  assign rd.en   = (state_r == RD_ISSUE);
  assign rd.addr = addr_r;
  assign busy    = (state_r == RD_ISSUE) || dat_vld_r;

  assign out_strobe        = strobe_r;
  assign out_channel_index = idx_r;
  assign out_pulse_us      = pulse_r;
  assign out_frame_valid   = fv_r;
  assign out_last          = last_r;

endmodule

// ===== hw/rtl/ppm_capture_decoder_core.sv =====
// ppm capture decoder top level: config registers, command accept, store and read paths
// depends on ppmcd_pkg, ppmcd_store, ppmcd_capture, ppmcd_reader and the macros header
//
// usage
//   a command transfer happens on a clock edge with start high and busy low.
//   in_kind 0 is a capture timestamp; it updates the decoder in that cycle and
//   gives no result. busy stays low, so captures can follow every cycle while
//   no read holds busy. in_kind 1 reads the frame. with a new frame pending,
//   eight results follow, channel 0 first, one per cycle, via the memory read
//   register and the output register; busy is high until the last width leaves
//   the memory read register, so no command is taken before then. the walk is
//   paced by the single read port of the width memory, one entry per cycle.
//   with no frame pending the read gives one invalid result in the next cycle.
//   each result is on the out_ ports for one cycle with out_strobe high; the
//   receiver cannot stall them. cfg_we writes register cfg_index at once.
//   reset (rst_n low, synchronous) restores the register defaults, clears the
//   slot index, previous timestamp and frame flag, and makes every stored
//   width read as 2400 ticks until written. no clearing pass is needed.
module ppm_capture_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [ppmcd_pkg::CAP_W-1:0]       in_capture_time,
  output logic                              out_strobe,
  output logic [ppmcd_pkg::IDX_W-1:0]       out_channel_index,
  output logic [ppmcd_pkg::PULSE_W-1:0]     out_pulse_us,
  output logic                              out_frame_valid,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [ppmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppmcd_pkg::CAP_W-1:0]       cfg_data
);
  import ppmcd_pkg::*;

  `include "ppm_capture_decoder_core_macros.svh"

  logic [CAP_W-1:0]   timer_top_r;
  logic [CAP_W-1:0]   sync_gap_r;
  logic [MINCH_W-1:0] min_ch_r;
  logic [PULSE_W-1:0] min_pulse_r;
  logic [PULSE_W-1:0] max_pulse_r;

  logic       accept;
  logic       cap_go;
  logic       rd_go;
  logic       new_frame;
  wr_req_t    wr;
  rd_req_t    rd;
  logic [CAP_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r <= TIMER_TOP_RESET;
      sync_gap_r  <= SYNC_GAP_RESET;
      min_ch_r    <= MIN_CH_RESET;
      min_pulse_r <= MIN_PULSE_RESET;
      max_pulse_r <= MAX_PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIMER_TOP: timer_top_r <= cfg_data;
        REG_SYNC_GAP:  sync_gap_r  <= cfg_data;
        REG_MIN_CH:    min_ch_r    <= cfg_data[MINCH_W-1:0];
        REG_MIN_PULSE: min_pulse_r <= cfg_data[PULSE_W-1:0];
        REG_MAX_PULSE: max_pulse_r <= cfg_data[PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = start && !busy;
  assign cap_go = accept && (in_kind == KIND_CAPTURE);
  assign rd_go  = accept && (in_kind == KIND_READ);

  ppmcd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  ppmcd_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .cap_go       (cap_go),
    .cap_time     (in_capture_time),
    .frame_clr    (rd_go),
    .timer_top    (timer_top_r),
    .sync_gap     (sync_gap_r),
    .min_ch       (min_ch_r),
    .wr           (wr),
    .new_frame    (new_frame)
  );

  ppmcd_reader u_reader (
    .clk               (clk),
    .rst_n             (rst_n),
    .rd_go             (rd_go),
    .new_frame         (new_frame),
    .rd_data           (rd_data),
    .min_pulse         (min_pulse_r),
    .max_pulse         (max_pulse_r),
    .rd                (rd),
    .busy              (busy),
    .out_strobe        (out_strobe),
    .out_channel_index (out_channel_index),
    .out_pulse_us      (out_pulse_us),
    .out_frame_valid   (out_frame_valid),
    .out_last          (out_last)
  );

  `PPMCD_ASSERT(a_invalid_is_last, !(out_strobe && !out_frame_valid) || out_last, "invalid result not last")
  `PPMCD_ASSERT(a_last_is_final_ch, !(out_strobe && out_frame_valid && out_last) || (out_channel_index == IDX_W'(READ_COUNT - 1)), "frame ends on wrong channel")
  `PPMCD_ASSERT_NEXT(a_burst_contiguous, out_strobe && !out_last, out_strobe && out_frame_valid, "gap inside frame burst")
  `PPMCD_ASSERT(a_no_write_during_read, !(wr.en && rd.en), "width write during read walk")

endmodule
